// ===== design/rpa_pkg.sv =====
`default_nettype none

package rpa_pkg;

  // default sizes, handed to the top level parameters
  localparam int WINDOW_PERIODS_DEF = 5;
  localparam int PERIOD_BITS_DEF    = 20;
  localparam int SAMPLE_BITS_DEF    = 16;

  // register port and fixed field widths
  localparam int LEVEL_W    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 32;
  localparam int DRIVE_W    = 16;
  localparam int FRAC_BITS  = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_LEVEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = 2'd1;

  localparam logic [LEVEL_W-1:0] RELAY_LEVEL_RST     = 15'd20480;
  localparam logic [LEVEL_W-1:0] START_THRESHOLD_RST = 15'd2048;

  // ziegler-nichols constants, scaled to integers
  localparam int K_DEN_W = 22;
  localparam int K_P_W   = 22;
  localparam int K_I_W   = 33;
  localparam int K_D_W   = 9;
  localparam logic [K_DEN_W-1:0] K_DEN = 22'd3141592;
  localparam logic [K_P_W-1:0]   K_P   = 22'd2400000;
  localparam logic [K_I_W-1:0]   K_I   = 33'd4800000000;
  localparam logic [K_D_W-1:0]   K_D   = 9'd300;

  // stability bound: 50 * deviation must not exceed the sum
  localparam int STAB_W = 6;
  localparam logic [STAB_W-1:0] STAB_K = 6'd50;

  // serial arithmetic unit operations
  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

`default_nettype wire

// ===== design/rpa_if.sv =====
`default_nettype none

// sample request channel
interface rpa_in_if #(
  parameter int SAMPLE_BITS = rpa_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          start_req;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          ms_tick;

  modport source (output valid, output start_req, output sample, output ms_tick,
                  input ready);
  modport sink (input valid, input start_req, input sample, input ms_tick,
                output ready);
endinterface

// result request channel
interface rpa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rpa_pkg::DRIVE_W-1:0]   drive_level;
  logic                                 busy_res;
  logic                                 tuning_done;
  logic                                 gain_error;
  logic        [rpa_pkg::GAIN_W-1:0]    gain_p;
  logic        [rpa_pkg::GAIN_W-1:0]    gain_i;
  logic        [rpa_pkg::GAIN_W-1:0]    gain_d;

  modport source (output valid, output drive_level, output busy_res,
                  output tuning_done, output gain_error, output gain_p,
                  output gain_i, output gain_d, input ready);
  modport sink (input valid, input drive_level, input busy_res,
                input tuning_done, input gain_error, input gain_p,
                input gain_i, input gain_d, output ready);
endinterface

// register write channel
interface rpa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rpa_pkg::CFG_IDX_W-1:0]    index;
  logic [rpa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/relay_pid_autotuner_top.sv =====
// Relay-feedback PID autotuner.
// in_ch carries one request per plant sample: start_req, sample, ms_tick.
// out_ch returns exactly one result request per sample: relay drive, busy,
// done and error flags and the three held Q16.16 gains.
// cfg_ch writes relay_level (index 0) and start_threshold (index 1); it is
// always ready, unknown indexes are dropped.
// An ordinary sample is accepted, then the result register loads from the emit state.
// The sample that completes a stable window of WINDOW_PERIODS periods first
// runs a window sum and check pass over the history, one bit-serial multiply
// and four bit-serial divides in the shared serial arithmetic unit.
// An unstable or zero-mean window runs only the sum and check passes.
// Reset puts the tuner in idle with gains and flags cleared and the
// registers at their defaults; the history fills during a run.
// When out_ch stalls, the result waits in the output register and one more
// sample is accepted and worked; its result then waits until the register
// is free, and in_ch holds ready low meanwhile.
`default_nettype none

module relay_pid_autotuner_top #(
  parameter int WINDOW_PERIODS = rpa_pkg::WINDOW_PERIODS_DEF,
  parameter int PERIOD_BITS    = rpa_pkg::PERIOD_BITS_DEF,
  parameter int SAMPLE_BITS    = rpa_pkg::SAMPLE_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rpa_in_if.sink     in_ch,
  rpa_out_if.source  out_ch,
  rpa_cfg_if.sink    cfg_ch
);

  localparam int WB    = $clog2(WINDOW_PERIODS + 1);
  localparam int AMP_W = SAMPLE_BITS + 1;
  localparam int SA_W  = AMP_W + WB;
  localparam int SP_W  = PERIOD_BITS + WB;
  localparam int DEN_W = rpa_pkg::K_DEN_W + SA_W;
  localparam int NUM_D = 40 + PERIOD_BITS + WB;
  localparam int NUM_I = 64 + 2 * WB;
  localparam int NUM_W = ((NUM_D > NUM_I) ? NUM_D : NUM_I) + 1;
  localparam int LV_W  = rpa_pkg::LEVEL_W;
  localparam int KP_W  = rpa_pkg::K_P_W + LV_W;
  localparam int KI_W  = rpa_pkg::K_I_W + LV_W;
  localparam int KD_W  = rpa_pkg::K_D_W + LV_W;
  localparam int GW    = rpa_pkg::GAIN_W;
  localparam int STAB_SHIFT = rpa_pkg::STAB_W;

  // tuner phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_RISE = 3'd1;
  localparam logic [2:0] PH_FALL = 3'd2;
  localparam logic [2:0] PH_NEG  = 3'd3;
  localparam logic [2:0] PH_POS  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  // sequencer states
  localparam logic [3:0] S_WAIT  = 4'd0;
  localparam logic [3:0] S_EMIT  = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_JUDGE = 4'd4;
  localparam logic [3:0] S_DMUL  = 4'd5;
  localparam logic [3:0] S_PDIV  = 4'd6;
  localparam logic [3:0] S_I1    = 4'd7;
  localparam logic [3:0] S_I2    = 4'd8;
  localparam logic [3:0] S_DDIV  = 4'd9;

  localparam logic [1:0] FLAG_DONE = 2'b01;
  localparam logic [1:0] FLAG_ERR  = 2'b10;

  localparam logic [WB-1:0] LAST_IDX = WB'(WINDOW_PERIODS - 1);

  logic [3:0]                    state_r, state_nxt;
  logic [2:0]                    phase_r, phase_nxt;
  logic [PERIOD_BITS-1:0]        ms_r, ms_nxt;
  logic signed [SAMPLE_BITS-1:0] low_r, low_nxt;
  logic signed [SAMPLE_BITS-1:0] high_r, high_nxt;
  logic [WB-1:0]                 piw_r, piw_nxt;
  logic [1:0]                    flags_r, flags_nxt;
  logic [GW-1:0]                 gain_r [3];
  logic [GW-1:0]                 gain_nxt [3];
  logic [WB-1:0]                 cnt_r, cnt_nxt;
  logic [SA_W-1:0]               sa_r, sa_nxt;
  logic [SP_W-1:0]               sp_r, sp_nxt;
  logic                          fail_r, fail_nxt;
  logic [DEN_W-1:0]              den_r, den_nxt;
  logic [KP_W-1:0]               kp_base_r, kp_base_nxt;
  logic [KI_W-1:0]               ki_base_r, ki_base_nxt;
  logic [KD_W-1:0]               kd_base_r, kd_base_nxt;
  logic [NUM_W-1:0]              kd_num_r, kd_num_nxt;
  logic [NUM_W-1:0]              tmp_r, tmp_nxt;
  logic                          issued_r, issued_nxt;
  logic [LV_W-1:0]               level_r;
  logic [LV_W-1:0]               thresh_r;

  logic [AMP_W-1:0]              amp_hist_r [WINDOW_PERIODS];
  logic [PERIOD_BITS-1:0]        per_hist_r [WINDOW_PERIODS];
  logic                          push;
  logic                          rot;
  logic [AMP_W-1:0]              push_amp;
  logic [PERIOD_BITS-1:0]        push_per;

  logic                          out_valid_r;
  logic signed [rpa_pkg::DRIVE_W-1:0] out_drive_r;
  logic                          out_busy_r;
  logic                          out_done_r;
  logic                          out_err_r;
  logic [GW-1:0]                 out_gain_r [3];
  logic                          out_load;

  logic                          in_acc;
  logic signed [SAMPLE_BITS-1:0] s;
  logic signed [SAMPLE_BITS+15:0] s_ext;
  logic signed [SAMPLE_BITS+15:0] thr_ext;
  logic                          s_le0;
  logic [PERIOD_BITS-1:0]        ms_tk;
  logic signed [SAMPLE_BITS-1:0] high_tk;

  logic [SA_W-1:0]               amp_sc, amp_dev;
  logic [SP_W-1:0]               per_sc, per_dev;
  logic                          amp_bad, per_bad;

  rpa_pkg::alu_req_t             alu_req;
  rpa_pkg::alu_stat_t            alu_stat;
  logic [NUM_W-1:0]              alu_a, alu_b, alu_res;
  logic [GW-1:0]                 alu_sat;

  rpa_serial_alu #(.NUM_W(NUM_W)) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (alu_a),
    .opb    (alu_b),
    .stat   (alu_stat),
    .result (alu_res)
  );

  // handshakes
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_WAIT);
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // sample decode
  assign s       = in_ch.sample;
  assign s_ext   = {{16{s[SAMPLE_BITS-1]}}, s};
  assign thr_ext = {{(SAMPLE_BITS + 1){1'b0}}, thresh_r};
  assign s_le0   = s[SAMPLE_BITS-1] || (s == '0);
  assign ms_tk   = (in_ch.ms_tick && (ms_r != '1)) ? ms_r + 1'b1 : ms_r;
  assign high_tk = (s > high_r) ? s : high_r;

  // window check on the entry at the head of the history
  assign amp_sc  = SA_W'(amp_hist_r[0]) * SA_W'(WINDOW_PERIODS);
  assign amp_dev = (amp_sc > sa_r) ? amp_sc - sa_r : sa_r - amp_sc;
  assign amp_bad = ((SA_W + STAB_SHIFT)'(amp_dev) * (SA_W + STAB_SHIFT)'(rpa_pkg::STAB_K))
                   > (SA_W + STAB_SHIFT)'(sa_r);
  assign per_sc  = SP_W'(per_hist_r[0]) * SP_W'(WINDOW_PERIODS);
  assign per_dev = (per_sc > sp_r) ? per_sc - sp_r : sp_r - per_sc;
  assign per_bad = ((SP_W + STAB_SHIFT)'(per_dev) * (SP_W + STAB_SHIFT)'(rpa_pkg::STAB_K))
                   > (SP_W + STAB_SHIFT)'(sp_r);

  assign alu_sat = (|alu_res[NUM_W-1:GW]) ? '1 : alu_res[GW-1:0];

  // sequencer and tuner update
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    ms_nxt      = ms_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    piw_nxt     = piw_r;
    flags_nxt   = flags_r;
    gain_nxt[0] = gain_r[0];
    gain_nxt[1] = gain_r[1];
    gain_nxt[2] = gain_r[2];
    cnt_nxt     = cnt_r;
    sa_nxt      = sa_r;
    sp_nxt      = sp_r;
    fail_nxt    = fail_r;
    den_nxt     = den_r;
    kp_base_nxt = kp_base_r;
    ki_base_nxt = ki_base_r;
    kd_base_nxt = kd_base_r;
    kd_num_nxt  = kd_num_r;
    tmp_nxt     = tmp_r;
    issued_nxt  = issued_r;
    push        = 1'b0;
    rot         = 1'b0;
    push_amp    = AMP_W'({high_tk[SAMPLE_BITS-1], high_tk} - {low_r[SAMPLE_BITS-1], low_r});
    push_per    = ms_tk;
    alu_req     = '0;
    alu_a       = '0;
    alu_b       = '0;
    case (state_r)
      S_WAIT: begin
        if (in_acc) begin
          state_nxt = S_EMIT;
          case (phase_r)
            PH_RISE: begin
              if (s_ext >= thr_ext) phase_nxt = PH_FALL;
            end
            PH_FALL: begin
              if (s_le0) begin
                ms_nxt    = '0;
                low_nxt   = '0;
                high_nxt  = '0;
                phase_nxt = PH_NEG;
              end
            end
            PH_NEG: begin
              ms_nxt = ms_tk;
              if (s < low_r) low_nxt = s;
              if (!s[SAMPLE_BITS-1]) phase_nxt = PH_POS;
            end
            PH_POS: begin
              ms_nxt   = ms_tk;
              high_nxt = high_tk;
              if (s_le0) begin
                push = 1'b1;
                if (piw_r == LAST_IDX) begin
                  piw_nxt   = '0;
                  state_nxt = S_SUM;
                  cnt_nxt   = '0;
                  sa_nxt    = '0;
                  sp_nxt    = '0;
                  fail_nxt  = 1'b0;
                end else begin
                  piw_nxt   = piw_r + 1'b1;
                  ms_nxt    = '0;
                  low_nxt   = '0;
                  high_nxt  = '0;
                  phase_nxt = PH_NEG;
                end
              end
            end
            default: begin
              if (in_ch.start_req) begin
                phase_nxt   = PH_RISE;
                piw_nxt     = '0;
                flags_nxt   = '0;
                gain_nxt[0] = '0;
                gain_nxt[1] = '0;
                gain_nxt[2] = '0;
              end else if (phase_r != PH_DONE) begin
                phase_nxt = PH_IDLE;
              end
            end
          endcase
        end
      end
      S_SUM: begin
        rot     = 1'b1;
        sa_nxt  = sa_r + SA_W'(amp_hist_r[0]);
        sp_nxt  = sp_r + SP_W'(per_hist_r[0]);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        rot     = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (amp_bad || per_bad) fail_nxt = 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_JUDGE;
        end
      end
      S_JUDGE: begin
        if (fail_r) begin
          ms_nxt    = '0;
          low_nxt   = '0;
          high_nxt  = '0;
          phase_nxt = PH_NEG;
          state_nxt = S_EMIT;
        end else if ((sa_r == '0) || (sp_r == '0)) begin
          phase_nxt   = PH_DONE;
          flags_nxt   = FLAG_ERR;
          gain_nxt[0] = '1;
          gain_nxt[1] = '1;
          gain_nxt[2] = '1;
          state_nxt   = S_EMIT;
        end else begin
          phase_nxt   = PH_DONE;
          den_nxt     = DEN_W'(rpa_pkg::K_DEN) * DEN_W'(sa_r);
          kp_base_nxt = KP_W'(rpa_pkg::K_P) * KP_W'(level_r);
          ki_base_nxt = KI_W'(rpa_pkg::K_I) * KI_W'(level_r);
          kd_base_nxt = KD_W'(rpa_pkg::K_D) * KD_W'(level_r);
          state_nxt   = S_DMUL;
        end
      end
      S_DMUL: begin
        // 300 * level * period sum, then the Q16 scale
        alu_a = NUM_W'(kd_base_r);
        alu_b = NUM_W'(sp_r);
        if (!issued_r) begin
          alu_req.start = 1'b1;
          alu_req.op    = rpa_pkg::ALU_MUL;
          issued_nxt    = 1'b1;
        end else if (alu_stat.done) begin
          kd_num_nxt = alu_res << rpa_pkg::FRAC_BITS;
          issued_nxt = 1'b0;
          state_nxt  = S_PDIV;
        end
      end
      S_PDIV: begin
        alu_a = (NUM_W'(kp_base_r) * NUM_W'(WINDOW_PERIODS)) << rpa_pkg::FRAC_BITS;
        alu_b = NUM_W'(den_r);
        if (!issued_r) begin
          alu_req.start = 1'b1;
          alu_req.op    = rpa_pkg::ALU_DIV;
          issued_nxt    = 1'b1;
        end else if (alu_stat.done) begin
          gain_nxt[0] = alu_sat;
          issued_nxt  = 1'b0;
          state_nxt   = S_I1;
        end
      end
      S_I1: begin
        alu_a = (NUM_W'(ki_base_r) * NUM_W'(WINDOW_PERIODS * WINDOW_PERIODS))
                << rpa_pkg::FRAC_BITS;
        alu_b = NUM_W'(den_r);
        if (!issued_r) begin
          alu_req.start = 1'b1;
          alu_req.op    = rpa_pkg::ALU_DIV;
          issued_nxt    = 1'b1;
        end else if (alu_stat.done) begin
          tmp_nxt    = alu_res;
          issued_nxt = 1'b0;
          state_nxt  = S_I2;
        end
      end
      S_I2: begin
        alu_a = tmp_r;
        alu_b = NUM_W'(sp_r);
        if (!issued_r) begin
          alu_req.start = 1'b1;
          alu_req.op    = rpa_pkg::ALU_DIV;
          issued_nxt    = 1'b1;
        end else if (alu_stat.done) begin
          gain_nxt[1] = alu_sat;
          issued_nxt  = 1'b0;
          state_nxt   = S_DDIV;
        end
      end
      S_DDIV: begin
        alu_a = kd_num_r;
        alu_b = NUM_W'(den_r);
        if (!issued_r) begin
          alu_req.start = 1'b1;
          alu_req.op    = rpa_pkg::ALU_DIV;
          issued_nxt    = 1'b1;
        end else if (alu_stat.done) begin
          gain_nxt[2] = alu_sat;
          flags_nxt   = FLAG_DONE;
          issued_nxt  = 1'b0;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) state_nxt = S_WAIT;
      end
      default: begin
        state_nxt = S_WAIT;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_WAIT;
      phase_r   <= PH_IDLE;
      ms_r      <= '0;
      low_r     <= '0;
      high_r    <= '0;
      piw_r     <= '0;
      flags_r   <= '0;
      gain_r[0] <= '0;
      gain_r[1] <= '0;
      gain_r[2] <= '0;
      cnt_r     <= '0;
      fail_r    <= 1'b0;
      issued_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      ms_r      <= ms_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      piw_r     <= piw_nxt;
      flags_r   <= flags_nxt;
      gain_r[0] <= gain_nxt[0];
      gain_r[1] <= gain_nxt[1];
      gain_r[2] <= gain_nxt[2];
      cnt_r     <= cnt_nxt;
      fail_r    <= fail_nxt;
      issued_r  <= issued_nxt;
    end
  end

  // window arithmetic operands
  always_ff @(posedge clk) begin
    sa_r      <= sa_nxt;
    sp_r      <= sp_nxt;
    den_r     <= den_nxt;
    kp_base_r <= kp_base_nxt;
    ki_base_r <= ki_base_nxt;
    kd_base_r <= kd_base_nxt;
    kd_num_r  <= kd_num_nxt;
    tmp_r     <= tmp_nxt;
  end

  // history shift line: push at the tail, rotate during the window pass
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < WINDOW_PERIODS - 1; i++) begin
        amp_hist_r[i] <= amp_hist_r[i+1];
        per_hist_r[i] <= per_hist_r[i+1];
      end
      amp_hist_r[WINDOW_PERIODS-1] <= push_amp;
      per_hist_r[WINDOW_PERIODS-1] <= push_per;
    end else if (rot) begin
      for (int i = 0; i < WINDOW_PERIODS - 1; i++) begin
        amp_hist_r[i] <= amp_hist_r[i+1];
        per_hist_r[i] <= per_hist_r[i+1];
      end
      amp_hist_r[WINDOW_PERIODS-1] <= amp_hist_r[0];
      per_hist_r[WINDOW_PERIODS-1] <= per_hist_r[0];
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= rpa_pkg::RELAY_LEVEL_RST;
      thresh_r <= rpa_pkg::START_THRESHOLD_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        rpa_pkg::REG_RELAY_LEVEL:     level_r  <= cfg_ch.data[LV_W-1:0];
        rpa_pkg::REG_START_THRESHOLD: thresh_r <= cfg_ch.data[LV_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if ((phase_r == PH_RISE) || (phase_r == PH_NEG)) begin
        out_drive_r <= {1'b0, level_r};
      end else if ((phase_r == PH_FALL) || (phase_r == PH_POS)) begin
        out_drive_r <= -$signed({1'b0, level_r});
      end else begin
        out_drive_r <= '0;
      end
      out_busy_r    <= (phase_r == PH_RISE) || (phase_r == PH_FALL) ||
                       (phase_r == PH_NEG) || (phase_r == PH_POS);
      out_done_r    <= flags_r[0];
      out_err_r     <= flags_r[1];
      out_gain_r[0] <= gain_r[0];
      out_gain_r[1] <= gain_r[1];
      out_gain_r[2] <= gain_r[2];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_level = out_drive_r;
  assign out_ch.busy_res    = out_busy_r;
  assign out_ch.tuning_done = out_done_r;
  assign out_ch.gain_error  = out_err_r;
  assign out_ch.gain_p      = out_gain_r[0];
  assign out_ch.gain_i      = out_gain_r[1];
  assign out_ch.gain_d      = out_gain_r[2];

`ifndef SYNTHESIS
  // period count never reaches a full window
  a_piw_range: assert property (@(posedge clk) disable iff (!rst_n)
    piw_r < WB'(WINDOW_PERIODS))
    else $error("period count out of range");

  // done and error are exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r != (FLAG_DONE | FLAG_ERR))
    else $error("done and error both set");

  // flags only while the run has finished
  a_flags_phase: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r != '0 |-> phase_r == PH_DONE)
    else $error("flags set outside done phase");

  // serial unit is started only when free
  a_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_stat.busy)
    else $error("serial unit started while busy");

  // an accepted request always leaves the wait state
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_WAIT)
    else $error("accepted request not processed");
`endif

endmodule

`default_nettype wire

// ===== design/rpa_serial_alu.sv =====
`default_nettype none

module rpa_serial_alu #(
  parameter int NUM_W = 71
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rpa_pkg::alu_req_t req,
  input  wire logic [NUM_W-1:0]  opa,
  input  wire logic [NUM_W-1:0]  opb,
  output rpa_pkg::alu_stat_t     stat,
  output logic [NUM_W-1:0]       result
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W:0]   acc_r, acc_nxt;
  logic [NUM_W-1:0] sh_r, sh_nxt;
  logic [NUM_W-1:0] b_r, b_nxt;
  logic [NUM_W:0]   rem_sh;

  // one bit per cycle: shift-add multiply or restoring divide
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    b_nxt    = b_r;
    rem_sh   = {acc_r[NUM_W-1:0], sh_r[NUM_W-1]};
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = CNT_W'(NUM_W);
      acc_nxt  = '0;
      sh_nxt   = opa;
      b_nxt    = opb;
    end else if (busy_r) begin
      if (op_r == rpa_pkg::ALU_MUL) begin
        if (b_r[0]) begin
          acc_nxt = acc_r + {1'b0, sh_r};
        end
        sh_nxt = {sh_r[NUM_W-2:0], 1'b0};
        b_nxt  = {1'b0, b_r[NUM_W-1:1]};
      end else begin
        if (rem_sh >= {1'b0, b_r}) begin
          acc_nxt = rem_sh - {1'b0, b_r};
          sh_nxt  = {sh_r[NUM_W-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh;
          sh_nxt  = {sh_r[NUM_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= rpa_pkg::ALU_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    b_r   <= b_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = (op_r == rpa_pkg::ALU_MUL) ? acc_r[NUM_W-1:0] : sh_r;

endmodule

`default_nettype wire

// ===== test/relay_pid_autotuner_top_tb.sv =====
`timescale 1ns / 1ps

module relay_pid_autotuner_top_tb;

  localparam int WIN        = rpa_pkg::WINDOW_PERIODS_DEF;
  localparam int MS_MAX     = (1 << rpa_pkg::PERIOD_BITS_DEF) - 1;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 500;
  localparam int ITEM_GOAL  = 2000;

  typedef enum logic [2:0] {
    TP_IDLE, TP_RISE, TP_FALL, TP_NEG, TP_POS, TP_DONE
  } tune_phase_t;

  typedef struct packed {
    logic signed [rpa_pkg::DRIVE_W-1:0] drive_level;
    logic                      busy_res;
    logic                      tuning_done;
    logic                      gain_error;
    logic [rpa_pkg::GAIN_W-1:0]         gain_p;
    logic [rpa_pkg::GAIN_W-1:0]         gain_i;
    logic [rpa_pkg::GAIN_W-1:0]         gain_d;
  } tune_result_t;

  // tracks the tuner state and holds the expected results in order
  class autotune_scoreboard_t;
    tune_result_t expected_q[$];
    int          errors;
    int          checked;
    int          done_runs;
    int          error_runs;
    bit [14:0]   relay_lvl;
    bit [14:0]   start_thr;
    tune_phase_t ph;
    int unsigned ms_cnt;
    int          low_seen;
    int          high_seen;
    longint unsigned amp_hist[WIN];
    longint unsigned per_hist[WIN];
    int          win_cnt;
    bit [31:0]   gains[3];
    bit [1:0]    flags;

    function new();
      relay_lvl = rpa_pkg::RELAY_LEVEL_RST;
      start_thr = rpa_pkg::START_THRESHOLD_RST;
      ph = TP_IDLE;
      ms_cnt = 0; low_seen = 0; high_seen = 0; win_cnt = 0; flags = 0;
      foreach (gains[i]) gains[i] = 0;
      foreach (amp_hist[i]) begin
        amp_hist[i] = 0;
        per_hist[i] = 0;
      end
      errors = 0; checked = 0; done_runs = 0; error_runs = 0;
    endfunction

    function void write_reg(logic [rpa_pkg::CFG_IDX_W-1:0] idx,
                            logic [rpa_pkg::CFG_DATA_W-1:0] d);
      if (idx == rpa_pkg::REG_RELAY_LEVEL) relay_lvl = d[14:0];
      else if (idx == rpa_pkg::REG_START_THRESHOLD) start_thr = d[14:0];
    endfunction

    function void begin_period();
      ms_cnt = 0; low_seen = 0; high_seen = 0; ph = TP_NEG;
    endfunction

    function bit hist_stable(longint unsigned h[WIN], longint unsigned sum);
      longint unsigned sc, dev;
      for (int i = 0; i < WIN; i++) begin
        sc = h[i] * WIN;
        dev = (sc > sum) ? sc - sum : sum - sc;
        if (dev * 50 > sum) return 0;
      end
      return 1;
    endfunction

    function bit [31:0] sat32(bit [127:0] v);
      return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // window close: stability test then ziegler-nichols gains
    function void close_window();
      longint unsigned sa, sp;
      bit [127:0] den, num, q;
      sa = 0; sp = 0;
      for (int i = 0; i < WIN; i++) begin
        sa += amp_hist[i];
        sp += per_hist[i];
      end
      if (!hist_stable(amp_hist, sa) || !hist_stable(per_hist, sp)) begin
        begin_period();
        return;
      end
      ph = TP_DONE;
      if (sa == 0 || sp == 0) begin
        foreach (gains[i]) gains[i] = 32'hFFFF_FFFF;
        flags = 2'b10;
        error_runs++;
        return;
      end
      den = 128'd3141592 * 128'(sa);
      num = 128'd2400000 * 128'(relay_lvl) * 128'(WIN) * 128'd65536;
      gains[0] = sat32(num / den);
      num = 128'd4800000000 * 128'(relay_lvl) * 128'(WIN * WIN) * 128'd65536;
      q = num / den;
      gains[1] = sat32(q / 128'(sp));
      num = 128'd300 * 128'(relay_lvl) * 128'(sp) * 128'd65536;
      gains[2] = sat32(num / den);
      flags = 2'b01;
      done_runs++;
    endfunction

    function void note_sample(bit st, logic signed [15:0] smp, bit tk);
      int s;
      tune_result_t r;
      s = smp;
      case (ph)
        TP_RISE: if (s >= int'(start_thr)) ph = TP_FALL;
        TP_FALL: if (s <= 0) begin_period();
        TP_NEG: begin
          if (tk && ms_cnt < MS_MAX) ms_cnt++;
          if (s < low_seen) low_seen = s;
          if (s >= 0) ph = TP_POS;
        end
        TP_POS: begin
          if (tk && ms_cnt < MS_MAX) ms_cnt++;
          if (s > high_seen) high_seen = s;
          if (s <= 0) begin
            for (int i = 0; i < WIN - 1; i++) begin
              amp_hist[i] = amp_hist[i+1];
              per_hist[i] = per_hist[i+1];
            end
            amp_hist[WIN-1] = longint'(high_seen - low_seen);
            per_hist[WIN-1] = ms_cnt;
            win_cnt++;
            if (win_cnt >= WIN) begin
              win_cnt = 0;
              close_window();
            end else begin
              begin_period();
            end
          end
        end
        default: begin
          if (st) begin
            ph = TP_RISE;
            win_cnt = 0;
            flags = 0;
            foreach (gains[i]) gains[i] = 0;
          end else if (ph != TP_DONE) begin
            ph = TP_IDLE;
          end
        end
      endcase
      if (ph == TP_RISE || ph == TP_NEG) r.drive_level = 16'(relay_lvl);
      else if (ph == TP_FALL || ph == TP_POS) r.drive_level = -16'(relay_lvl);
      else r.drive_level = 0;
      r.busy_res = (ph >= TP_RISE && ph <= TP_POS);
      r.tuning_done = flags[0];
      r.gain_error = flags[1];
      r.gain_p = gains[0];
      r.gain_i = gains[1];
      r.gain_d = gains[2];
      expected_q.push_back(r);
    endfunction

    function void check_result(tune_result_t act);
      tune_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, act);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (act.drive_level !== e.drive_level) begin
        $display("%0t: drive_level expected %0d actual %0d", $time, e.drive_level,
                 act.drive_level);
        errors++;
      end
      if (act.busy_res !== e.busy_res) begin
        $display("%0t: busy_res expected %0b actual %0b", $time, e.busy_res, act.busy_res);
        errors++;
      end
      if (act.tuning_done !== e.tuning_done) begin
        $display("%0t: tuning_done expected %0b actual %0b", $time, e.tuning_done,
                 act.tuning_done);
        errors++;
      end
      if (act.gain_error !== e.gain_error) begin
        $display("%0t: gain_error expected %0b actual %0b", $time, e.gain_error,
                 act.gain_error);
        errors++;
      end
      if (act.gain_p !== e.gain_p) begin
        $display("%0t: gain_p expected %h actual %h", $time, e.gain_p, act.gain_p);
        errors++;
      end
      if (act.gain_i !== e.gain_i) begin
        $display("%0t: gain_i expected %h actual %h", $time, e.gain_i, act.gain_i);
        errors++;
      end
      if (act.gain_d !== e.gain_d) begin
        $display("%0t: gain_d expected %h actual %h", $time, e.gain_d, act.gain_d);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rpa_in_if  in_ch();
  rpa_out_if out_ch();
  rpa_cfg_if cfg_ch();

  relay_pid_autotuner_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  autotune_scoreboard_t sb = new();
  int  sent_items;
  int  cfg_writes;
  bit  quiet_stretch;
  int  idle_cycles;

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit roll_idle();
    if (quiet_stretch) return 1'b0;
    return $urandom_range(99) < 34;
  endfunction

  // result side: random backpressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !roll_idle();
  end

  // result checks and watchdog, sampled mid-cycle
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.drive_level, out_ch.busy_res, out_ch.tuning_done,
                          out_ch.gain_error, out_ch.gain_p, out_ch.gain_i, out_ch.gain_d});
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // one sample request, sometimes with a random gap in front
  task automatic send_sample(bit st, logic signed [15:0] smp, bit tk);
    bit acc;
    if (roll_idle()) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.start_req <= st;
    in_ch.sample    <= smp;
    in_ch.ms_tick   <= tk;
    acc = 0;
    while (!acc) begin
      @(negedge clk);
      if (in_ch.ready) begin
        acc = 1;
        sb.note_sample(st, smp, tk);
      end
      @(posedge clk);
    end
    sent_items++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [rpa_pkg::CFG_IDX_W-1:0] idx,
                           logic [rpa_pkg::CFG_DATA_W-1:0] d);
    bit acc;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    acc = 0;
    while (!acc) begin
      @(negedge clk);
      if (cfg_ch.ready) begin
        acc = 1;
        sb.write_reg(idx, d);
      end
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one tuning run with well-formed oscillation periods
  task automatic tune_run(int amp_n, int amp_p, int nlen, int plen, int nper,
                          int jitter_pct);
    int thr, s, n, p;
    bit tk_all;
    thr = sb.start_thr;
    tk_all = $urandom_range(3) != 0;
    send_sample(1'b1, 16'($urandom), $urandom_range(1));
    // rise
    repeat ($urandom_range(0, 3))
      if (thr > 0) send_sample($urandom_range(9) == 0, 16'($urandom_range(thr - 1)), 1'b1);
    send_sample(1'b0, 16'($urandom_range(32767, thr)), 1'b1);
    // fall
    repeat ($urandom_range(0, 2)) send_sample(1'b0, 16'($urandom_range(32767, 1)), 1'b1);
    send_sample(1'b0, $urandom_range(1) ? 16'sd0 : -16'($urandom_range(32768, 1)), 1'b1);
    for (int k = 0; k < nper; k++) begin
      n = nlen; p = plen;
      if ($urandom_range(99) < jitter_pct) begin
        n = nlen + $urandom_range(3);
        p = plen + $urandom_range(2);
      end
      for (int i = 0; i < n; i++) begin
        s = (i == 0) ? -amp_n : -int'($urandom_range(amp_n, 1));
        send_sample($urandom_range(19) == 0, 16'(s), tk_all | $urandom_range(1));
      end
      for (int i = 0; i < p; i++) begin
        s = (i == p - 1) ? amp_p : int'($urandom_range(amp_p, 1));
        send_sample($urandom_range(19) == 0, 16'(s), tk_all | $urandom_range(1));
      end
      s = $urandom_range(1) ? 0 : -int'($urandom_range(amp_n, 1));
      send_sample(1'b0, 16'(s), tk_all | $urandom_range(1));
    end
  endtask

  // run whose periods have no amplitude and no ticks
  task automatic flat_run();
    send_sample(1'b1, 16'sd0, 1'b0);
    send_sample(1'b0, 16'(sb.start_thr), 1'b0);
    send_sample(1'b0, 16'sd0, 1'b0);
    repeat (WIN) begin
      send_sample(1'b0, 16'sd0, 1'b0);
      send_sample(1'b0, 16'sd0, 1'b0);
    end
    send_sample(1'b0, 16'sd0, 1'b0);
  endtask

  task automatic noise_items(int cnt);
    repeat (cnt) send_sample($urandom_range(3) == 0, 16'($urandom), $urandom_range(1));
  endtask

  // stimulus
  initial begin
    int kind;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.start_req <= 1'b0;
    in_ch.sample <= '0;
    in_ch.ms_tick <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    sent_items = 0; cfg_writes = 0; quiet_stretch = 0; idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, extremes, zero means, unknown index
    send_sample(1'b0, 16'sh7FFF, 1'b1);
    send_sample(1'b0, 16'sh8000, 1'b0);
    tune_run(32768, 32767, 2, 2, WIN, 0);
    wait_drained();
    write_reg(rpa_pkg::REG_RELAY_LEVEL, 16'hFFFF);
    write_reg(rpa_pkg::REG_START_THRESHOLD, 16'h0000);
    write_reg(2'd2, 16'h1234);
    write_reg(2'd3, 16'hFFFF);
    flat_run();
    wait_drained();
    write_reg(rpa_pkg::REG_RELAY_LEVEL, 16'h0000);
    write_reg(rpa_pkg::REG_START_THRESHOLD, 16'h7FFF);
    tune_run(1, 1, 2, 2, WIN, 0);
    wait_drained();

    // random runs
    while (sent_items < ITEM_GOAL) begin
      quiet_stretch = (sent_items > 800 && sent_items < 1100);
      if ($urandom_range(2) == 0) begin
        wait_drained();
        write_reg(rpa_pkg::REG_RELAY_LEVEL, pick_level());
        write_reg(rpa_pkg::REG_START_THRESHOLD,
                  $urandom_range(3) == 0 ? pick_level() : 16'($urandom_range(4096)));
      end
      kind = $urandom_range(99);
      if (kind < 70)
        tune_run($urandom_range(32768, 1), $urandom_range(32767, 1), $urandom_range(2, 5),
                 $urandom_range(2, 5), $urandom_range(WIN, 3 * WIN), $urandom_range(30));
      else if (kind < 82)
        flat_run();
      else
        noise_items($urandom_range(5, 30));
      // sender holds off until every result is back
      if ($urandom_range(7) == 0) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_q.size() != 0);
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("samples %0d, results checked %0d, register writes %0d", sent_items,
             sb.checked, cfg_writes);
    $display("runs tuned %0d, runs with zero mean %0d", sb.done_runs, sb.error_runs);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
